@@ design/ced_pkg.sv @@
// Shared types, constants and small helper functions for the Canny edge stream.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ced_pkg;

   // Geometry defaults and the fixed coordinate width carried in a job.
   localparam int MAX_WIDTH_DEFAULT  = 2048;
   localparam int MAX_HEIGHT_DEFAULT = 2048;
   localparam int COORD_W            = 13;
   localparam int RING_W             = 4;
   localparam int RING_LINES         = 16;

   // Field widths.
   localparam int LUMA_W = 8;
   localparam int MAG_W  = 11;
   localparam int SEC_W  = 2;
   localparam int GRAD_W = MAG_W + SEC_W;
   localparam int THR_W  = 11;
   localparam int ZLIM_W = 8;
   localparam int GEOM_W = 12;
   localparam int CSR_ADDR_W = 3;
   localparam int MAG_MAX = 1443;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_LOW_THRESHOLD  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HIGH_THRESHOLD = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ZERO_LIMIT     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LINE_WIDTH     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_HEIGHT   = 3'd4;

   // Register reset values.
   localparam logic [THR_W-1:0]  LOW_THRESHOLD_RESET  = 11'd18;
   localparam logic [THR_W-1:0]  HIGH_THRESHOLD_RESET = 11'd23;
   localparam logic [ZLIM_W-1:0] ZERO_LIMIT_RESET     = 8'd3;
   localparam logic [GEOM_W-1:0] LINE_WIDTH_RESET     = 12'd640;
   localparam logic [GEOM_W-1:0] FRAME_HEIGHT_RESET   = 12'd480;

   // Request kinds.
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // Gradient direction sectors.
   localparam logic [SEC_W-1:0] SEC_HORIZ     = 2'd0;
   localparam logic [SEC_W-1:0] SEC_DIAG_UP   = 2'd1;
   localparam logic [SEC_W-1:0] SEC_VERT      = 2'd2;
   localparam logic [SEC_W-1:0] SEC_DIAG_DOWN = 2'd3;

   // One owed result: its position, the ring slot of its frame's first row and its flags.
   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [RING_W-1:0]  base;
      logic               last_line;
      logic               last_frame;
   } job_type;

   // Clamp a position into [0, n-1].
   function automatic int clampi(input int v, input int n);
      int res;
      if (v < 0) begin
         res = 0;
      end else if (v >= n) begin
         res = n - 1;
      end else begin
         res = v;
      end
      return res;
   endfunction

   // Row offset of entry k of a 3x3 window in raster order.
   function automatic int tap_dy(input logic [3:0] k);
      int res;
      case (k)
         4'd0, 4'd1, 4'd2: begin
            res = -1;
         end
         4'd3, 4'd4, 4'd5: begin
            res = 0;
         end
         default: begin
            res = 1;
         end
      endcase
      return res;
   endfunction

   // Column offset of entry k of a 3x3 window in raster order.
   function automatic int tap_dx(input logic [3:0] k);
      int res;
      case (k)
         4'd0, 4'd3, 4'd6: begin
            res = -1;
         end
         4'd1, 4'd4, 4'd7: begin
            res = 0;
         end
         default: begin
            res = 1;
         end
      endcase
      return res;
   endfunction

   // Neighbor step along a gradient sector.
   function automatic int sector_dy(input logic [SEC_W-1:0] s);
      int res;
      case (s)
         SEC_HORIZ: begin
            res = 0;
         end
         default: begin
            res = -1;
         end
      endcase
      return res;
   endfunction

   function automatic int sector_dx(input logic [SEC_W-1:0] s);
      int res;
      case (s)
         SEC_HORIZ, SEC_DIAG_UP: begin
            res = 1;
         end
         SEC_VERT: begin
            res = 0;
         end
         default: begin
            res = -1;
         end
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

@@ design/ced_front.sv @@
// Front part: accepts requests, converts pixels to luma, keeps the luma line ring
// and decides which requests release a result. Uses ced_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ced_front #(
   parameter int MAX_WIDTH  = ced_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = ced_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata,   // red, green, blue
   input  logic req_tuser,          // kind
   input  logic restart,
   input  logic [$clog2(MAX_WIDTH):0] width_eff,
   input  logic [$clog2(MAX_HEIGHT):0] height_eff,
   input  logic q_full,
   output logic q_push,
   output ced_pkg::job_type q_job,
   input  logic [ced_pkg::RING_W+$clog2(MAX_WIDTH)-1:0] rd_addr,
   output logic [ced_pkg::LUMA_W-1:0] rd_data
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int MEM_DEPTH = ced_pkg::RING_LINES << XW;

   logic [XW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [YW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [ced_pkg::RING_W-1:0] in_base_ff, in_base_in, out_base_ff, out_base_in;
   logic out_behind_ff, out_behind_in;
   logic accept, is_pixel, avail;
   logic [15:0] luma_sum;
   logic [ced_pkg::LUMA_W-1:0] luma;
   logic [ced_pkg::RING_W+XW-1:0] wr_addr;
   logic [ced_pkg::LUMA_W-1:0] luma_mem [MEM_DEPTH];

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign is_pixel   = (req_tuser == ced_pkg::KIND_PIXEL);
   assign q_push     = accept && avail;

   // Luma with weights 69/172/15 over 256, rounded.
   assign luma_sum = 16'(req_tdata[7:0]) * 16'd69 + 16'(req_tdata[15:8]) * 16'd172
                   + 16'(req_tdata[23:16]) * 16'd15 + 16'd128;
   assign luma     = luma_sum[15:8];
   assign wr_addr  = {ced_pkg::RING_W'(int'(in_base_ff) + int'(in_row_ff)), in_col_ff};

   // Position bookkeeping for one accepted request.
   always_comb begin
      int w, h, ic, ir, oc, orw, dr, dc;
      logic [ced_pkg::RING_W-1:0] ib, ob;
      logic beh;
      w   = int'(width_eff);
      h   = int'(height_eff);
      ic  = int'(in_col_ff);
      ir  = int'(in_row_ff);
      oc  = int'(out_col_ff);
      orw = int'(out_row_ff);
      ib  = in_base_ff;
      ob  = out_base_ff;
      beh = out_behind_ff;
      if (is_pixel) begin
         if (ic + 1 >= w) begin
            ic = 0;
            if (ir + 1 >= h) begin
               ir  = 0;
               ib  = ced_pkg::RING_W'(int'(in_base_ff) + h);
               beh = 1'b1;
            end else begin
               ir = ir + 1;
            end
         end else begin
            ic = ic + 1;
         end
      end
      dr = (orw + 3 > h - 1) ? h - 1 : orw + 3;
      dc = (oc + 3 > w - 1) ? w - 1 : oc + 3;
      avail = beh || (ir > dr) || (ir == dr && ic > dc);

      q_job.row        = ced_pkg::COORD_W'(out_row_ff);
      q_job.col        = ced_pkg::COORD_W'(out_col_ff);
      q_job.base       = out_base_ff;
      q_job.last_line  = (oc == w - 1);
      q_job.last_frame = (oc == w - 1) && (orw == h - 1);

      // The released result moves the output position on.
      if (avail) begin
         if (oc + 1 >= w) begin
            oc = 0;
            if (orw + 1 >= h) begin
               orw = 0;
               ob  = ced_pkg::RING_W'(int'(out_base_ff) + h);
               beh = 1'b0;
            end else begin
               orw = orw + 1;
            end
         end else begin
            oc = oc + 1;
         end
      end
      in_col_in     = XW'(ic);
      in_row_in     = YW'(ir);
      in_base_in    = ib;
      out_col_in    = XW'(oc);
      out_row_in    = YW'(orw);
      out_base_in   = ob;
      out_behind_in = beh;
   end

   // Position registers.
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         in_base_ff    <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         out_base_ff   <= '0;
         out_behind_ff <= 1'b0;
      end else if (accept) begin
         in_col_ff     <= in_col_in;
         in_row_ff     <= in_row_in;
         in_base_ff    <= in_base_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         out_base_ff   <= out_base_in;
         out_behind_ff <= out_behind_in;
      end
   end

   // Luma line ring: written by accepted pixels, read by the back part.
   always_ff @(posedge clock) begin
      if (accept && is_pixel) begin
         luma_mem[wr_addr] <= luma;
      end
      rd_data <= luma_mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ design/ced_queue.sv @@
// Two-entry queue of owed results between the front and the back part.
// Uses ced_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module ced_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  ced_pkg::job_type push_job,
   output logic full,
   input  logic pop,
   output logic empty,
   output ced_pkg::job_type head
);

   ced_pkg::job_type entry_ff [2];
   logic [1:0] count_ff;
   logic wr_ptr_ff, rd_ptr_ff;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("Queue written while full.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("Queue read while empty.");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("Queue count out of range.");

endmodule

`default_nettype wire

@@ design/ced_back.sv @@
// Back part: evaluates one owed result at a time (Sobel, direction, magnitude,
// suppression, hysteresis) and holds the response register. Uses ced_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ced_back #(
   parameter int MAX_WIDTH  = ced_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = ced_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic [$clog2(MAX_WIDTH):0] width_eff,
   input  logic [$clog2(MAX_HEIGHT):0] height_eff,
   input  logic [ced_pkg::THR_W-1:0] low_threshold,
   input  logic [ced_pkg::THR_W-1:0] high_threshold,
   input  logic [ced_pkg::ZLIM_W-1:0] zero_limit,
   input  logic q_empty,
   input  ced_pkg::job_type q_head,
   output logic q_pop,
   output logic [ced_pkg::RING_W+$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  logic [ced_pkg::LUMA_W-1:0] rd_data,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [15:0] rsp_tdata,   // edge_strength (11 bits), zero padded
   output logic rsp_tlast,          // last_in_line
   output logic rsp_tuser           // last_in_frame
);

   localparam int XW = $clog2(MAX_WIDTH);

   typedef enum logic [3:0] {
      S_IDLE, S_GREAD, S_GABS, S_GMUL, S_GDIR, S_GSQRT, S_GWRITE,
      S_SUPA, S_SUPB, S_SUPC, S_SUPD, S_HYS, S_OUT
   } state_type;

   state_type state_ff;
   ced_pkg::job_type job_ff;
   logic [2:0] gi_ff, gj_ff;
   logic [3:0] tap_ff, si_ff, hk_ff, iter_ff;
   logic [1:0] mstep_ff;
   logic signed [11:0] gx_ff, gy_ff;
   logic [9:0] ax_ff, ay_ff;
   logic [21:0] psum_ff, pdiff_ff, pax_ff, pay_ff;
   logic [ced_pkg::SEC_W-1:0] sec_ff, gsec_ff;
   logic [21:0] rem_ff, res_ff, bit_ff;
   logic [ced_pkg::MAG_W-1:0] gmag_ff, n1_ff, hr_mag_ff;
   logic [ced_pkg::GRAD_W-1:0] gr_ff;
   logic strong_ff;
   logic [ced_pkg::GRAD_W-1:0] grad_ff [25];
   logic [ced_pkg::MAG_W-1:0] sup_ff [9];

   logic [4:0] gidx, gw_idx;
   logic [3:0] sidx;
   logic signed [11:0] lv, lv2;
   logic [10:0] mop;
   logic [21:0] prod, trial;
   logic [ced_pkg::SEC_W-1:0] sec_new;
   logic [ced_pkg::MAG_W-1:0] mag, n2_mag, sup_val, center, edge_val;
   logic out_free;

   // Window addressing: luma reads, gradient grid and suppressed grid indexes.
   always_comb begin
      int r, c, h, w, yg, xg, ra, ca, pr, pc, nr, nc, hr, hc, dy, dx;
      logic [ced_pkg::SEC_W-1:0] sec_sel;
      r  = int'(job_ff.row);
      c  = int'(job_ff.col);
      h  = int'(height_eff);
      w  = int'(width_eff);
      yg = ced_pkg::clampi(r + int'(gi_ff) - 2, h);
      xg = ced_pkg::clampi(c + int'(gj_ff) - 2, w);
      ra = ced_pkg::clampi(yg + ced_pkg::tap_dy(tap_ff), h);
      ca = ced_pkg::clampi(xg + ced_pkg::tap_dx(tap_ff), w);
      rd_addr = {ced_pkg::RING_W'(int'(job_ff.base) + ra), XW'(ca)};

      pr = ced_pkg::clampi(r + ced_pkg::tap_dy(si_ff), h);
      pc = ced_pkg::clampi(c + ced_pkg::tap_dx(si_ff), w);
      sec_sel = (state_ff == S_SUPB) ? gr_ff[ced_pkg::GRAD_W-1:ced_pkg::MAG_W] : gsec_ff;
      dy = ced_pkg::sector_dy(sec_sel);
      dx = ced_pkg::sector_dx(sec_sel);
      case (state_ff)
         S_SUPB: begin
            nr = ced_pkg::clampi(pr + dy, h);
            nc = ced_pkg::clampi(pc + dx, w);
         end
         S_SUPC: begin
            nr = ced_pkg::clampi(pr - dy, h);
            nc = ced_pkg::clampi(pc - dx, w);
         end
         default: begin
            nr = pr;
            nc = pc;
         end
      endcase
      gidx   = 5'((nr - r + 2) * 5 + (nc - c + 2));
      gw_idx = 5'(int'(gi_ff) * 5 + int'(gj_ff));

      hr   = ced_pkg::clampi(r + ced_pkg::tap_dy(hk_ff), h);
      hc   = ced_pkg::clampi(c + ced_pkg::tap_dx(hk_ff), w);
      sidx = 4'((hr - r + 1) * 3 + (hc - c + 1));
   end

   // Arithmetic shared by the gradient steps.
   assign lv  = signed'({4'd0, rd_data});
   assign lv2 = lv <<< 1;

   always_comb begin
      case (mstep_ff)
         2'd0: begin
            mop = 11'(ax_ff) + 11'(ay_ff);
         end
         2'd1: begin
            mop = (ay_ff > ax_ff) ? 11'(ay_ff - ax_ff) : 11'd0;
         end
         2'd2: begin
            mop = 11'(ax_ff);
         end
         default: begin
            mop = 11'(ay_ff);
         end
      endcase
   end

   assign prod  = 22'(mop) * 22'(mop);
   assign trial = res_ff + bit_ff;
   assign mag   = ced_pkg::MAG_W'(res_ff) + ((rem_ff > res_ff) ? 11'd1 : 11'd0);

   // Direction sector from the registered squares.
   always_comb begin
      logic [9:0] lim;
      lim = 10'(zero_limit);
      if (ax_ff <= lim) begin
         sec_new = (ay_ff <= lim) ? ced_pkg::SEC_HORIZ : ced_pkg::SEC_VERT;
      end else if (23'(psum_ff) < {pax_ff, 1'b0}) begin
         sec_new = ced_pkg::SEC_HORIZ;
      end else if (ay_ff > ax_ff && 23'(pdiff_ff) > {pax_ff, 1'b0}) begin
         sec_new = ced_pkg::SEC_VERT;
      end else begin
         sec_new = ((gx_ff > 12'sd0) == (gy_ff > 12'sd0)) ? ced_pkg::SEC_DIAG_UP
                                                         : ced_pkg::SEC_DIAG_DOWN;
      end
   end

   assign n2_mag   = gr_ff[ced_pkg::MAG_W-1:0];
   assign sup_val  = (n1_ff > gmag_ff || n2_mag > gmag_ff) ? '0 : gmag_ff;
   assign center   = sup_ff[4];
   assign edge_val = (center > low_threshold && strong_ff) ? center : '0;
   assign out_free = !rsp_tvalid || rsp_tready;
   assign q_pop    = (state_ff == S_IDLE) && !q_empty;

   // Registered reads of the small grids.
   always_ff @(posedge clock) begin
      gr_ff     <= grad_ff[gidx];
      hr_mag_ff <= sup_ff[sidx];
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         rsp_tvalid <= 1'b0;
      end else begin
         // The output state loads the response itself when the register frees up.
         if (rsp_tvalid && rsp_tready && state_ff != S_OUT) begin
            rsp_tvalid <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  job_ff   <= q_head;
                  gi_ff    <= '0;
                  gj_ff    <= '0;
                  tap_ff   <= '0;
                  gx_ff    <= '0;
                  gy_ff    <= '0;
                  state_ff <= S_GREAD;
               end
            end
            // One luma tap a cycle; data arrives in the cycle after its address.
            S_GREAD: begin
               if (tap_ff != 4'd0) begin
                  case (ced_pkg::tap_dx(tap_ff - 4'd1) * (ced_pkg::tap_dy(tap_ff - 4'd1) == 0 ? 2 : 1))
                     2: gx_ff <= gx_ff + lv2;
                     1: gx_ff <= gx_ff + lv;
                     -1: gx_ff <= gx_ff - lv;
                     -2: gx_ff <= gx_ff - lv2;
                     default: gx_ff <= gx_ff;
                  endcase
                  case (-ced_pkg::tap_dy(tap_ff - 4'd1) * (ced_pkg::tap_dx(tap_ff - 4'd1) == 0 ? 2 : 1))
                     2: gy_ff <= gy_ff + lv2;
                     1: gy_ff <= gy_ff + lv;
                     -1: gy_ff <= gy_ff - lv;
                     -2: gy_ff <= gy_ff - lv2;
                     default: gy_ff <= gy_ff;
                  endcase
               end
               if (tap_ff == 4'd9) begin
                  state_ff <= S_GABS;
               end else begin
                  tap_ff <= tap_ff + 4'd1;
               end
            end
            S_GABS: begin
               ax_ff    <= (gx_ff < 12'sd0) ? 10'(-gx_ff) : 10'(gx_ff);
               ay_ff    <= (gy_ff < 12'sd0) ? 10'(-gy_ff) : 10'(gy_ff);
               mstep_ff <= '0;
               state_ff <= S_GMUL;
            end
            // One square a cycle through the single multiplier.
            S_GMUL: begin
               case (mstep_ff)
                  2'd0: psum_ff <= prod;
                  2'd1: pdiff_ff <= prod;
                  2'd2: pax_ff <= prod;
                  default: pay_ff <= prod;
               endcase
               mstep_ff <= mstep_ff + 2'd1;
               if (mstep_ff == 2'd3) begin
                  state_ff <= S_GDIR;
               end
            end
            S_GDIR: begin
               sec_ff   <= sec_new;
               rem_ff   <= pax_ff + pay_ff;
               res_ff   <= '0;
               bit_ff   <= 22'd1 << 20;
               iter_ff  <= '0;
               state_ff <= S_GSQRT;
            end
            // Integer square root, one result bit a cycle.
            S_GSQRT: begin
               if (rem_ff >= trial) begin
                  rem_ff <= rem_ff - trial;
                  res_ff <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff  <= bit_ff >> 2;
               iter_ff <= iter_ff + 4'd1;
               if (iter_ff == 4'd10) begin
                  state_ff <= S_GWRITE;
               end
            end
            S_GWRITE: begin
               grad_ff[gw_idx] <= {sec_ff, mag};
               tap_ff <= '0;
               gx_ff  <= '0;
               gy_ff  <= '0;
               if (gj_ff == 3'd4) begin
                  gj_ff <= '0;
                  if (gi_ff == 3'd4) begin
                     si_ff    <= '0;
                     state_ff <= S_SUPA;
                  end else begin
                     gi_ff    <= gi_ff + 3'd1;
                     state_ff <= S_GREAD;
                  end
               end else begin
                  gj_ff    <= gj_ff + 3'd1;
                  state_ff <= S_GREAD;
               end
            end
            // Suppression: read the pixel, then both neighbors along its sector.
            S_SUPA: begin
               state_ff <= S_SUPB;
            end
            S_SUPB: begin
               gmag_ff  <= gr_ff[ced_pkg::MAG_W-1:0];
               gsec_ff  <= gr_ff[ced_pkg::GRAD_W-1:ced_pkg::MAG_W];
               state_ff <= S_SUPC;
            end
            S_SUPC: begin
               n1_ff    <= gr_ff[ced_pkg::MAG_W-1:0];
               state_ff <= S_SUPD;
            end
            S_SUPD: begin
               sup_ff[si_ff] <= sup_val;
               if (si_ff == 4'd8) begin
                  hk_ff     <= '0;
                  strong_ff <= 1'b0;
                  state_ff  <= S_HYS;
               end else begin
                  si_ff    <= si_ff + 4'd1;
                  state_ff <= S_SUPA;
               end
            end
            // Hysteresis: any of the nine suppressed values above the high level.
            S_HYS: begin
               if (hk_ff != 4'd0 && hr_mag_ff > high_threshold) begin
                  strong_ff <= 1'b1;
               end
               if (hk_ff == 4'd9) begin
                  state_ff <= S_OUT;
               end else begin
                  hk_ff <= hk_ff + 4'd1;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_tvalid <= 1'b1;
                  rsp_tdata  <= 16'(edge_val);
                  rsp_tlast  <= job_ff.last_line;
                  rsp_tuser  <= job_ff.last_frame;
                  state_ff   <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GWRITE |-> mag <= ced_pkg::MAG_W'(ced_pkg::MAG_MAX))
      else $error("Gradient magnitude out of range.");

   a_frame_end_is_line_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("Frame end flagged away from a line end.");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && out_free |=> rsp_tvalid && state_ff == S_IDLE)
      else $error("Response not loaded.");

endmodule

`default_nettype wire

@@ design/canny_edge_stream.sv @@
// Top level of the streaming Canny edge detector: configuration registers and the
// front part, queue and back part. Uses ced_pkg, ced_front, ced_queue, ced_back.
//
// Requests carry one RGB pixel (tuser low) or a flush (tuser high). Each request
// releases at most one edge result in raster order; with pixels only, the result for
// pixel p leaves with pixel p + 3*width + 3, and flushes drain the rest. A result is
// computed by one shared back-end sequencer: 25 gradient evaluations (nine luma reads
// from the single read port of the line ring, four squares through one multiplier,
// an eleven-step square root), then suppression and hysteresis. Two released results
// can wait in the queue while the front keeps taking requests. A write to line_width
// or frame_height restarts the stream; configuration is to be written only while the
// block is idle: the user must see to this, the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module canny_edge_stream #(
   parameter int MAX_WIDTH  = ced_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = ced_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  logic req_tuser,          // kind
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [15:0] rsp_tdata,   // edge_strength [10:0], zero padded
   output logic rsp_tlast,          // last_in_line
   output logic rsp_tuser,          // last_in_frame
   input  logic csr_we,
   input  logic [ced_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [ced_pkg::GEOM_W-1:0] csr_wdata
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);

   logic [ced_pkg::THR_W-1:0] low_ff, high_ff;
   logic [ced_pkg::ZLIM_W-1:0] zlim_ff;
   logic [ced_pkg::GEOM_W-1:0] width_ff, height_ff;
   logic [XW:0] width_eff;
   logic [YW:0] height_eff;
   logic restart;
   logic q_full, q_empty, q_push, q_pop;
   ced_pkg::job_type q_job, q_head;
   logic [ced_pkg::RING_W+XW-1:0] rd_addr;
   logic [ced_pkg::LUMA_W-1:0] rd_data;

   assign restart = csr_we && (csr_addr == ced_pkg::CSR_LINE_WIDTH ||
                               csr_addr == ced_pkg::CSR_FRAME_HEIGHT);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff    <= ced_pkg::LOW_THRESHOLD_RESET;
         high_ff   <= ced_pkg::HIGH_THRESHOLD_RESET;
         zlim_ff   <= ced_pkg::ZERO_LIMIT_RESET;
         width_ff  <= ced_pkg::LINE_WIDTH_RESET;
         height_ff <= ced_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            ced_pkg::CSR_LOW_THRESHOLD: low_ff <= csr_wdata[ced_pkg::THR_W-1:0];
            ced_pkg::CSR_HIGH_THRESHOLD: high_ff <= csr_wdata[ced_pkg::THR_W-1:0];
            ced_pkg::CSR_ZERO_LIMIT: zlim_ff <= csr_wdata[ced_pkg::ZLIM_W-1:0];
            ced_pkg::CSR_LINE_WIDTH: width_ff <= csr_wdata;
            ced_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Geometry clamped to [3, maximum].
   always_comb begin
      int lw, lh;
      lw = int'(width_ff);
      lh = int'(height_ff);
      if (lw < 3) begin
         lw = 3;
      end else if (lw > MAX_WIDTH) begin
         lw = MAX_WIDTH;
      end
      if (lh < 3) begin
         lh = 3;
      end else if (lh > MAX_HEIGHT) begin
         lh = MAX_HEIGHT;
      end
      width_eff  = (XW + 1)'(lw);
      height_eff = (YW + 1)'(lh);
   end

   ced_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .restart(restart), .width_eff(width_eff), .height_eff(height_eff),
      .q_full(q_full), .q_push(q_push), .q_job(q_job),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   ced_queue u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_job(q_job), .full(q_full),
      .pop(q_pop), .empty(q_empty), .head(q_head)
   );

   ced_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
      .clock(clock), .reset(reset),
      .width_eff(width_eff), .height_eff(height_eff),
      .low_threshold(low_ff), .high_threshold(high_ff), .zero_limit(zlim_ff),
      .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
      .rd_addr(rd_addr), .rd_data(rd_data),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for canny_edge_stream: random pixel frames and flushes in,
// edge results checked against a predictor of luma, Sobel, suppression and hysteresis.
// Depends on ced_pkg and the canny_edge_stream RTL.
`timescale 1ns / 1ps

// Holds a bit-true predictor of the edge stream and the results it still expects.
class canny_predictor;
   typedef struct {
      logic [10:0] strength;
      logic        line_end;
      logic        frame_end;
   } edge_result_type;

   edge_result_type expected_edges[$];
   logic [7:0]   luma_ring[16][2048];
   int unsigned  low_thr, high_thr, zero_lim, width_reg, height_reg;
   int unsigned  in_col, in_row, out_col, out_row, in_slot, out_slot;
   bit           out_behind;
   int           eff_w, eff_h;
   int           mismatches;
   int           checked;

   function new();
      foreach (luma_ring[i, j]) luma_ring[i][j] = '0;
      low_thr    = ced_pkg::LOW_THRESHOLD_RESET;
      high_thr   = ced_pkg::HIGH_THRESHOLD_RESET;
      zero_lim   = ced_pkg::ZERO_LIMIT_RESET;
      width_reg  = ced_pkg::LINE_WIDTH_RESET;
      height_reg = ced_pkg::FRAME_HEIGHT_RESET;
      mismatches = 0;
      checked    = 0;
      restart_stream();
   endfunction

   function void restart_stream();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      in_slot = 0;
      out_slot = 0;
      out_behind = 0;
   endfunction

   function int clip(input int v, input int n);
      return (v < 0) ? 0 : ((v >= n) ? n - 1 : v);
   endfunction

   // Mirror a register write; geometry writes restart the stream.
   function void write_reg(input logic [2:0] addr, input logic [11:0] value);
      case (addr)
         ced_pkg::CSR_LOW_THRESHOLD: begin
            low_thr = value[10:0];
         end
         ced_pkg::CSR_HIGH_THRESHOLD: begin
            high_thr = value[10:0];
         end
         ced_pkg::CSR_ZERO_LIMIT: begin
            zero_lim = value[7:0];
         end
         ced_pkg::CSR_LINE_WIDTH: begin
            width_reg = value;
            restart_stream();
         end
         ced_pkg::CSR_FRAME_HEIGHT: begin
            height_reg = value;
            restart_stream();
         end
         default: begin
         end
      endcase
   endfunction

   function int luma_at(input int y, input int x);
      return luma_ring[(out_slot + y) & 15][clip(x, 2048)];
   endfunction

   // Square root rounded to nearest.
   function int round_root(input int v);
      int res;
      res = 0;
      for (int b = 15; b >= 0; b--) begin
         if ((res + (1 << b)) * (res + (1 << b)) <= v) res = res + (1 << b);
      end
      if (v - res * res > res) res++;
      return res;
   endfunction

   // Sobel magnitude at (y, x) and its direction sector.
   function int sobel_at(input int y, input int x, output logic [1:0] sec);
      int ym, yp, xm, xp, gx, gy, ax, ay;
      ym = clip(y - 1, eff_h);
      yp = clip(y + 1, eff_h);
      xm = clip(x - 1, eff_w);
      xp = clip(x + 1, eff_w);
      gx = (luma_at(ym, xp) + 2 * luma_at(y, xp) + luma_at(yp, xp))
         - (luma_at(ym, xm) + 2 * luma_at(y, xm) + luma_at(yp, xm));
      gy = (luma_at(ym, xm) + 2 * luma_at(ym, x) + luma_at(ym, xp))
         - (luma_at(yp, xm) + 2 * luma_at(yp, x) + luma_at(yp, xp));
      ax = (gx < 0) ? -gx : gx;
      ay = (gy < 0) ? -gy : gy;
      if (ax <= zero_lim) begin
         sec = (ay <= zero_lim) ? ced_pkg::SEC_HORIZ : ced_pkg::SEC_VERT;
      end else if ((ay + ax) * (ay + ax) < 2 * ax * ax) begin
         sec = ced_pkg::SEC_HORIZ;
      end else if (ay > ax && (ay - ax) * (ay - ax) > 2 * ax * ax) begin
         sec = ced_pkg::SEC_VERT;
      end else begin
         sec = ((gx > 0) == (gy > 0)) ? ced_pkg::SEC_DIAG_UP : ced_pkg::SEC_DIAG_DOWN;
      end
      return round_root(ax * ax + ay * ay);
   endfunction

   // Magnitude after non-maximum suppression.
   function int thinned_at(input int y, input int x);
      logic [1:0] sec, unused;
      int g, n1, n2, dy, dx;
      g = sobel_at(y, x, sec);
      case (sec)
         ced_pkg::SEC_HORIZ: begin
            dy = 0;
            dx = 1;
         end
         ced_pkg::SEC_DIAG_UP: begin
            dy = -1;
            dx = 1;
         end
         ced_pkg::SEC_VERT: begin
            dy = -1;
            dx = 0;
         end
         default: begin
            dy = -1;
            dx = -1;
         end
      endcase
      n1 = sobel_at(clip(y + dy, eff_h), clip(x + dx, eff_w), unused);
      n2 = sobel_at(clip(y - dy, eff_h), clip(x - dx, eff_w), unused);
      return (n1 > g || n2 > g) ? 0 : g;
   endfunction

   // Hysteresis: keep s if above the low level and s or a neighbor is strong.
   function int edge_at(input int y, input int x);
      int s;
      bit is_strong;
      s = thinned_at(y, x);
      is_strong = s > high_thr;
      if (s <= low_thr) return 0;
      for (int i = -1; i <= 1; i++) begin
         for (int j = -1; j <= 1; j++) begin
            if (!is_strong && (i != 0 || j != 0) &&
                thinned_at(clip(y + i, eff_h), clip(x + j, eff_w)) > high_thr)
               is_strong = 1;
         end
      end
      return is_strong ? s : 0;
   endfunction

   // Note an accepted request and queue the result it releases, if any.
   function void note_request(input logic kind, input logic [23:0] rgb);
      int unsigned luma, dr, dc;
      bit avail;
      edge_result_type res;
      eff_w = (width_reg < 3) ? 3 : ((width_reg > 2048) ? 2048 : width_reg);
      eff_h = (height_reg < 3) ? 3 : ((height_reg > 2048) ? 2048 : height_reg);
      if (kind == ced_pkg::KIND_PIXEL) begin
         luma = (69 * rgb[7:0] + 172 * rgb[15:8] + 15 * rgb[23:16] + 128) >> 8;
         luma_ring[(in_slot + in_row) & 15][clip(in_col, 2048)] = luma[7:0];
         if (++in_col >= eff_w) begin
            in_col = 0;
            if (++in_row >= eff_h) begin
               in_row = 0;
               in_slot = (in_slot + eff_h) & 15;
               out_behind = 1;
            end
         end
      end
      if (out_behind) begin
         avail = 1;
      end else begin
         dr = (out_row + 3 > eff_h - 1) ? eff_h - 1 : out_row + 3;
         dc = (out_col + 3 > eff_w - 1) ? eff_w - 1 : out_col + 3;
         avail = in_row > dr || (in_row == dr && in_col > dc);
      end
      if (!avail) return;
      res.strength  = 11'(edge_at(out_row, out_col));
      res.line_end  = out_col == eff_w - 1;
      res.frame_end = res.line_end && out_row == eff_h - 1;
      expected_edges.push_back(res);
      if (++out_col >= eff_w) begin
         out_col = 0;
         if (++out_row >= eff_h) begin
            out_row = 0;
            out_slot = (out_slot + eff_h) & 15;
            out_behind = 0;
         end
      end
   endfunction

   function void report(input string what, input logic [15:0] exp_v, input logic [15:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %s: expected %0d, got %0d (result %0d)", what, exp_v, got,
                  checked);
   endfunction

   // Compare one accepted result with the oldest expectation.
   function void check_result(input logic [15:0] data, input logic line_end,
                              input logic frame_end);
      edge_result_type res;
      checked++;
      if (expected_edges.size() == 0) begin
         report("unexpected result", 16'd0, data);
         return;
      end
      res = expected_edges.pop_front();
      if (data !== {5'd0, res.strength}) report("edge_strength", {5'd0, res.strength}, data);
      if (line_end !== res.line_end)
         report("last_in_line", 16'(res.line_end), 16'(line_end));
      if (frame_end !== res.frame_end)
         report("last_in_frame", 16'(res.frame_end), 16'(frame_end));
   endfunction
endclass

module testbench;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD      = 3000;
   localparam int SETTLE_CYCLES  = 1000;
   localparam int ITEM_TARGET    = 1850;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic [ced_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [ced_pkg::GEOM_W-1:0]     csr_wdata = '0;

   canny_predictor edges = new();
   int  items_sent = 0;
   int  idle_cycles = 0;
   bit  bursty = 0;
   bit  hold_request = 0;

   canny_edge_stream u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("testbench NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: random stalls, one long hold-off on request.
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = bursty ? 0 : $urandom_range(0, 18);
         if (hold_request) begin
            gap = LONG_HOLD;
            hold_request = 0;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         edges.check_result(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   task automatic write_csr(input logic [2:0] addr, input logic [11:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      edges.write_reg(addr, value);
   endtask

   // Offer one request and wait until it is taken.
   task automatic send_request(input logic kind, input logic [23:0] rgb);
      int gap;
      gap = bursty ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= rgb;
      do @(posedge clock); while (!req_tready);
      edges.note_request(kind, rgb);
      items_sent++;
   endtask

   // Drain completed frames with flushes, then wait for every result and let the block settle.
   task automatic drain_results();
      while (edges.out_behind) send_request(ced_pkg::KIND_FLUSH, 24'($urandom));
      req_tvalid <= 1'b0;
      while (edges.expected_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [23:0] make_pixel(input int style, input int r, input int c,
                                              input int w, input int h);
      logic [7:0] v;
      logic [23:0] noise;
      noise = 24'($urandom);
      case (style)
         0: return 24'($urandom);
         1: v = 8'(r * 37 + c * 23 + noise[2:0]);
         default: v = (((c > w / 2) ^ (r > h / 2)) ? 8'd200 : 8'd30) + noise[2:0];
      endcase
      return {v ^ noise[18:16], v, v ^ noise[10:8]};
   endfunction

   // One setting of the registers followed by a run of pixels with scattered flushes.
   task automatic run_phase(input logic [11:0] w_raw, input logic [11:0] h_raw,
                            input int npix, input logic [11:0] lo, input logic [11:0] hi,
                            input logic [7:0] zl, input int style, input int flush_pct);
      int w, h;
      w = (w_raw < 3) ? 3 : ((w_raw > 2048) ? 2048 : w_raw);
      h = (h_raw < 3) ? 3 : ((h_raw > 2048) ? 2048 : h_raw);
      write_csr(ced_pkg::CSR_LOW_THRESHOLD, lo);
      write_csr(ced_pkg::CSR_HIGH_THRESHOLD, hi);
      write_csr(ced_pkg::CSR_ZERO_LIMIT, {4'd0, zl});
      write_csr(ced_pkg::CSR_LINE_WIDTH, w_raw);
      write_csr(ced_pkg::CSR_FRAME_HEIGHT, h_raw);
      for (int p = 0; p < npix; p++) begin
         if ($urandom_range(0, 99) < flush_pct)
            send_request(ced_pkg::KIND_FLUSH, 24'($urandom));
         send_request(ced_pkg::KIND_PIXEL, make_pixel(style, (p / w) % h, p % w, w, h));
      end
      drain_results();
   endtask

   initial begin
      logic [23:0] corner_pixels[9];
      int phase, w, h, lo;
      corner_pixels = '{24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000,
                        24'hFFFFFF, 24'h000000, 24'h204080, 24'hFFFFFF};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed: smallest frame, zero thresholds, channel extremes, flush with nothing owed.
      write_csr(ced_pkg::CSR_LOW_THRESHOLD, 12'd0);
      write_csr(ced_pkg::CSR_HIGH_THRESHOLD, 12'd0);
      write_csr(ced_pkg::CSR_ZERO_LIMIT, 12'd0);
      write_csr(ced_pkg::CSR_LINE_WIDTH, 12'd3);
      write_csr(ced_pkg::CSR_FRAME_HEIGHT, 12'd3);
      send_request(ced_pkg::KIND_FLUSH, 24'hFFFFFF);
      foreach (corner_pixels[i]) send_request(ced_pkg::KIND_PIXEL, corner_pixels[i]);
      drain_results();

      // Geometry extremes: clamped widest line, tallest frame with a ring wrap, thresholds
      // written with bit 11 set.
      run_phase(12'hFFF, 12'd0, 40, 12'd0, 12'd0, 8'd0, 0, 10);
      run_phase(12'd3, 12'hFFF, 90, 12'd10, 12'd40, 8'd255, 1, 10);
      run_phase(12'd3, 12'd20, 120, 12'd20, 12'd60, 8'd3, 2, 5);
      run_phase(12'd5, 12'd4, 40, 12'hFFF, 12'hFFF, 8'd255, 0, 10);

      // Long receiver hold-off while the sender keeps offering pixels.
      hold_request = 1;
      run_phase(12'd4, 12'd6, 72, 12'd5, 12'd30, 8'd2, 0, 0);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         phase++;
         bursty = (phase % 5 == 0);
         w = $urandom_range(3, 10);
         h = $urandom_range(3, 8);
         lo = $urandom_range(0, 150);
         run_phase((w == 3) ? 12'($urandom_range(0, 3)) : 12'(w),
                   (h == 3) ? 12'($urandom_range(0, 3)) : 12'(h),
                   w * h * $urandom_range(1, 3) + $urandom_range(0, w),
                   12'(lo), 12'(lo + $urandom_range(0, 250) - 40),
                   ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12)),
                   $urandom_range(0, 2), $urandom_range(0, 15));
      end
      bursty = 0;

      if (edges.mismatches == 0 && edges.expected_edges.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule
